// File: rtl/rkd_pkg.sv
// rkd_pkg: types and constants of the rotary knob event decoder
// no dependencies; used by rkd_core and rotary_knob_event_decoder
package rkd_pkg;

    localparam int unsigned TICKS_W = 8;
    localparam int unsigned POS_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam logic [TICKS_W-1:0] LONG_PRESS_TICKS_RST = 8'd60;
    localparam logic [POS_W-1:0] POS_MAX = 2'd3;

    typedef enum logic {
        CMD_PIN  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        PRESS_NONE = 2'd0,
        PRESS_DOWN = 2'd1,
        PRESS_UP   = 2'd2,
        PRESS_LONG = 2'd3
    } t_press;

    typedef enum logic [1:0] {
        TWIST_NONE  = 2'd0,
        TWIST_RIGHT = 2'd1,
        TWIST_LEFT  = 2'd2
    } t_twist;

    typedef enum logic {
        REG_LONG_PRESS_TICKS = 1'b0
    } t_reg;

    typedef struct packed {
        t_cmd             command;
        logic             push_level;
        logic [POS_W-1:0] quad_lines;
    } t_item;

    typedef struct packed {
        t_press press_event;
        t_twist twist_event;
    } t_result;

endpackage

// File: rtl/rkd_core.sv
// rkd_core: press timer, quadrature position and detent counter state
// with the single-pass update for one word; depends on rkd_pkg
module rkd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  rkd_pkg::t_item                i_item,
    input  logic [rkd_pkg::TICKS_W-1:0]   i_long_press_ticks,
    output rkd_pkg::t_result              o_result
);
    import rkd_pkg::*;

    logic [TICKS_W-1:0] r_press_timer;
    logic [TICKS_W-1:0] n_press_timer;
    logic [POS_W-1:0]   r_last_position;
    logic [POS_W-1:0]   n_last_position;
    logic [POS_W-1:0]   r_detent_count;
    logic [POS_W-1:0]   n_detent_count;

    logic [TICKS_W-1:0] timer_inc;
    logic [POS_W-1:0]   pos;
    logic               step_up;
    t_press             press;
    t_twist             twist;

    assign timer_inc = (r_press_timer != '0) ? r_press_timer + TICKS_W'(1) : '0;
    assign pos = {i_item.quad_lines[1], i_item.quad_lines[1] ^ i_item.quad_lines[0]};
    assign step_up = ((pos > r_last_position)
                      || (r_last_position == POS_MAX && pos == '0))
                     && !(r_last_position == '0 && pos == POS_MAX);

    always_comb begin
        n_press_timer   = r_press_timer;
        n_last_position = r_last_position;
        n_detent_count  = r_detent_count;
        press           = PRESS_NONE;
        twist           = TWIST_NONE;
        unique case (i_item.command)
            CMD_TICK: begin
                n_press_timer = timer_inc;
                if (timer_inc > i_long_press_ticks) begin
                    n_press_timer = '0;
                    press         = PRESS_LONG;
                end
            end
            CMD_PIN: begin
                if (!i_item.push_level) begin
                    n_press_timer = TICKS_W'(1);
                    press         = PRESS_DOWN;
                end else if (r_press_timer != '0) begin
                    n_press_timer = '0;
                    press         = PRESS_UP;
                end
                if (pos != r_last_position) begin
                    n_last_position = pos;
                    if (step_up) begin
                        n_detent_count = r_detent_count + POS_W'(1);
                        if (n_detent_count == POS_W'(0)) begin
                            twist = TWIST_RIGHT;
                        end
                    end else begin
                        n_detent_count = r_detent_count - POS_W'(1);
                        if (n_detent_count == POS_W'(2)) begin
                            twist = TWIST_LEFT;
                        end
                    end
                end
            end
            default: begin
                press = PRESS_NONE;
            end
        endcase
    end

    assign o_result.press_event = press;
    assign o_result.twist_event = twist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_timer   <= '0;
            r_last_position <= '0;
            r_detent_count  <= '0;
        end else if (i_step) begin
            r_press_timer   <= n_press_timer;
            r_last_position <= n_last_position;
            r_detent_count  <= n_detent_count;
        end
    end

`ifndef SYNTHESIS
    a_long_stops_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && press == PRESS_LONG |=> r_press_timer == '0)
        else $error("timer still running after long press");

    a_down_restarts_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && press == PRESS_DOWN |=> r_press_timer == TICKS_W'(1))
        else $error("timer not restarted on press");

    a_tick_no_twist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.command == CMD_TICK |=> $stable(r_last_position)
        && $stable(r_detent_count))
        else $error("tick moved the position state");
`endif

endmodule

// File: rtl/rotary_knob_event_decoder.sv
// rotary_knob_event_decoder: top level with input register, result register
// and the configuration port; depends on rkd_pkg and rkd_core
// Accepts one word per clock, unless the output stalls, and returns one result word
// for each. A word is captured in the input register and its result in the result
// register, from which it is presented; an output stall can hold the word in the
// input register in between. The knob state update is a single combinational pass
// from the input register into the result register, so the sustained rate is one
// word per cycle when the output is not stalled, set by that one state update. Register
// long_press_ticks sits at byte address 0 and resets to 60; write it only while no
// word is in flight.
module rotary_knob_event_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_command,
    input  logic                              i_push_level,
    input  logic [1:0]                        i_quad_lines,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_press_event,
    output logic [1:0]                        o_twist_event,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rkd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rkd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rkd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import rkd_pkg::*;

    logic               r_in_valid;
    t_item              r_in_item;
    logic               r_out_valid;
    t_result            r_out_result;
    logic [TICKS_W-1:0] r_long_press_ticks;

    logic    out_free;
    logic    step;
    logic    cfg_wr;
    t_reg    reg_sel;
    t_result core_result;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item.command    <= t_cmd'(i_command);
            r_in_item.push_level <= i_push_level;
            r_in_item.quad_lines <= i_quad_lines;
        end
    end

    rkd_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_item             (r_in_item),
        .i_long_press_ticks (r_long_press_ticks),
        .o_result           (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_result <= core_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_press_event = r_out_result.press_event;
    assign o_twist_event = r_out_result.twist_event;

    // register decode on the word address
    assign reg_sel = t_reg'(paddr[APB_ADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= LONG_PRESS_TICKS_RST;
        end else if (cfg_wr && reg_sel == REG_LONG_PRESS_TICKS) begin
            r_long_press_ticks <= pwdata[TICKS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_LONG_PRESS_TICKS: prdata = APB_DATA_W'(r_long_press_ticks);
            default:              prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid && !i_ready)
        else $error("input stalled without a blocked result");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed word did not reach the result register");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_in_item))
        else $error("waiting input word lost");
`endif

endmodule

// File: tb/sv/testbench.sv
// testbench for rotary_knob_event_decoder: self-checking, drives pin-change and tick words
// with random gaps and output stalls, predicts each result, programs long_press_ticks over apb
// depends on rkd_pkg and the rtl of rotary_knob_event_decoder
`timescale 1ns / 100ps

module testbench;
    import rkd_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT = 29;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_WORDS = 810;
    localparam int RANDOM_PHASES = 9;
    localparam logic [APB_ADDR_W-1:0] TICKS_ADDR = APB_ADDR_W'(4 * int'(REG_LONG_PRESS_TICKS));

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_command = 1'b0;
    logic                  i_push_level = 1'b1;
    logic [1:0]            i_quad_lines = 2'd0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_press_event;
    logic [1:0]            o_twist_event;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predicted knob state
    logic [TICKS_W-1:0] knob_threshold = LONG_PRESS_TICKS_RST;
    logic [TICKS_W-1:0] knob_timer = '0;
    logic [POS_W-1:0]   knob_pos = '0;
    logic [POS_W-1:0]   knob_detent = '0;

    t_result    knob_events_q[$];
    bit         steady = 1'b0;
    int         err_count = 0;
    int         cycle_count = 0;
    int         words_sent = 0;
    logic [1:0] gen_pos = 2'd0;

    always #CLK_HALF i_clk = ~i_clk;

    rotary_knob_event_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_push_level  (i_push_level),
        .i_quad_lines  (i_quad_lines),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_press_event (o_press_event),
        .o_twist_event (o_twist_event),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic t_result knob_predict(t_item w);
        t_result          r;
        logic [POS_W-1:0] pos;
        bit               up;
        r.press_event = PRESS_NONE;
        r.twist_event = TWIST_NONE;
        if (w.command == CMD_TICK) begin
            if (knob_timer != 0) knob_timer = knob_timer + 1'b1;
            if (knob_timer > knob_threshold) begin
                knob_timer = '0;
                r.press_event = PRESS_LONG;
            end
        end else begin
            if (!w.push_level) begin
                knob_timer = TICKS_W'(1);
                r.press_event = PRESS_DOWN;
            end else if (knob_timer != 0) begin
                knob_timer = '0;
                r.press_event = PRESS_UP;
            end
            pos = w.quad_lines ^ (w.quad_lines >> 1);
            if (pos != knob_pos) begin
                // jumps of two count as up only to a higher position; 3 to 0 wraps as up
                up = (pos > knob_pos || (knob_pos == POS_MAX && pos == 0))
                     && !(knob_pos == 0 && pos == POS_MAX);
                if (up) begin
                    knob_detent = knob_detent + 1'b1;
                    if (knob_detent == 0) r.twist_event = TWIST_RIGHT;
                end else begin
                    knob_detent = knob_detent - 1'b1;
                    if (knob_detent == 2) r.twist_event = TWIST_LEFT;
                end
                knob_pos = pos;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch %s: expected %0d, got %0d (t=%0t)", what, want, got, $realtime);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            knob_events_q.push_back(knob_predict(
                t_item'{t_cmd'(i_command), i_push_level, i_quad_lines}));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (knob_events_q.size() == 0) begin
                note_mismatch("unexpected word", 32'd0, 32'({o_press_event, o_twist_event}));
            end else begin
                if (o_press_event !== knob_events_q[0].press_event)
                    note_mismatch("press_event", 32'(knob_events_q[0].press_event),
                                  32'(o_press_event));
                if (o_twist_event !== knob_events_q[0].twist_event)
                    note_mismatch("twist_event", 32'(knob_events_q[0].twist_event),
                                  32'(o_twist_event));
                void'(knob_events_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(t_cmd cmd, logic lvl, logic [1:0] lines);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_push_level <= lvl;
        i_quad_lines <= lines;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic send_pin(logic lvl, logic [1:0] pos);
        gen_pos = pos;
        send_word(CMD_PIN, lvl, pos ^ (pos >> 1));
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (knob_events_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_access(bit wr, logic [TICKS_W-1:0] val, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TICKS_ADDR;
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [TICKS_W-1:0] val);
        logic [31:0] rd;
        wait_idle();
        reg_access(1'b1, val, rd);
        knob_threshold = val;
        reg_access(1'b0, '0, rd);
        if (rd !== 32'(val)) note_mismatch("long_press_ticks readback", 32'(val), rd);
    endtask

    task automatic test_reset_value();
        logic [31:0] rd;
        reg_access(1'b0, '0, rd);
        if (rd !== 32'(LONG_PRESS_TICKS_RST))
            note_mismatch("long_press_ticks after reset", 32'(LONG_PRESS_TICKS_RST), rd);
    endtask

    task automatic test_directed();
        steady = 1'b1;
        send_pin(1'b1, 2'd0);
        send_tick();
        send_pin(1'b1, 2'd1);
        send_pin(1'b1, 2'd2);
        send_pin(1'b1, 2'd3);
        // press and right detent together
        send_pin(1'b0, 2'd0);
        send_pin(1'b1, 2'd0);
        send_pin(1'b1, 2'd3);
        send_pin(1'b1, 2'd2);
        // skipped positions
        send_pin(1'b1, 2'd0);
        send_pin(1'b1, 2'd2);
        send_pin(1'b1, 2'd1);
        send_pin(1'b1, 2'd3);
        send_pin(1'b1, 2'd1);
        send_pin(1'b1, 2'd3);
        send_pin(1'b1, 2'd0);
        // held button re-reports on every pin change
        send_pin(1'b0, 2'd0);
        send_pin(1'b0, 2'd1);
        send_word(CMD_TICK, 1'b0, 2'b11);
        send_word(CMD_TICK, 1'b1, 2'b00);
        send_pin(1'b1, 2'd1);
        send_pin(1'b1, 2'd1);
        steady = 1'b0;
    endtask

    task automatic test_threshold(logic [TICKS_W-1:0] val);
        set_threshold(val);
        send_pin(1'b0, gen_pos);
        repeat (int'(val) + 2) send_tick();
        send_pin(1'b1, gen_pos);
        send_pin(1'b0, gen_pos);
        send_tick();
        send_pin(1'b1, gen_pos);
    endtask

    task automatic random_burst();
        int         kind;
        int         n;
        bit         dir;
        logic [1:0] step;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            dir = 1'($urandom_range(0, 1));
            n = $urandom_range(1, 10);
            repeat (n) begin
                step = ($urandom_range(0, 7) == 0) ? 2'd2 : 2'd1;
                send_pin(1'b1, dir ? gen_pos + step : gen_pos - step);
            end
        end else if (kind <= 6) begin
            send_pin(1'b0, gen_pos);
            n = $urandom_range(0, int'(knob_threshold) + 2);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_pin(1'b0, gen_pos + ($urandom_range(0, 1) ? 2'd1 : 2'd3));
                end else begin
                    send_tick();
                end
            end
            send_pin(1'b1, $urandom_range(0, 1) ? gen_pos : gen_pos + 2'd1);
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 3)) send_tick();
            send_pin(1'b1, gen_pos);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1)) begin
                    send_tick();
                end else begin
                    send_pin(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    task automatic test_random();
        logic [TICKS_W-1:0] phase_cfg [RANDOM_PHASES];
        int                 target;
        phase_cfg = '{8'd1, 8'd2, 8'd3, 8'd254, 8'd7, 8'd15, 8'd60, 8'd5, 8'd1};
        phase_cfg[7] = TICKS_W'($urandom_range(1, 40));
        target = words_sent;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_threshold(phase_cfg[p]);
            steady = (p == 4);
            target += RANDOM_WORDS / RANDOM_PHASES;
            while (words_sent < target) random_burst();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_value();
        test_directed();
        test_threshold(8'd1);
        test_threshold(8'd254);
        test_threshold(8'd0);
        test_threshold(8'd255);
        test_random();
        wait_idle();
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
